FILE: rtl/core/tldsim_pkg.sv
// ----------------------------------------------------------------------------
// tldsim_pkg
// Shared widths, register codes, reset values and control structs of the
// tandem line departure simulator.
// ----------------------------------------------------------------------------
package tldsim_pkg;

   // departure history and time format
   localparam int HISTORY_DEPTH      = 128;
   localparam int HIST_ADDR_WIDTH    = $clog2(HISTORY_DEPTH);
   localparam int TIME_FRACTION_BITS = 16;
   localparam int TIME_WIDTH         = 48;
   localparam int SERVICE_WIDTH      = 24;

   // counts and buffer sizes
   localparam int COUNT_WIDTH  = 16;
   localparam int BUFFER_WIDTH = 7;

   // throughput result, UQ16.16
   localparam int THROUGHPUT_WIDTH         = 32;
   localparam int THROUGHPUT_FRACTION_BITS = 16;
   localparam int DIVIDEND_WIDTH = COUNT_WIDTH + TIME_FRACTION_BITS + THROUGHPUT_FRACTION_BITS;
   localparam int DIV_COUNT_WIDTH = $clog2(DIVIDEND_WIDTH);

   // stream payload widths
   localparam int REQ_DATA_WIDTH = 3 * SERVICE_WIDTH;
   localparam int RSP_DATA_WIDTH = THROUGHPUT_WIDTH + TIME_WIDTH;
   localparam int RSP_USER_WIDTH = 1;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JOB_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BURNIN_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_BUFFER  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_BUFFER = 2'd3;

   localparam logic [COUNT_WIDTH-1:0]  JOB_COUNT_RESET     = 16'd2050;
   localparam logic [COUNT_WIDTH-1:0]  BURNIN_COUNT_RESET  = 16'd2000;
   localparam logic [BUFFER_WIDTH-1:0] BUFFER_SIZE_RESET   = 7'd64;

   // commands from controller to datapath, one active at a time
   typedef struct packed {
      logic load;
      logic step1;
      logic step2;
      logic step3;
      logic step4;
      logic wrap;
      logic div_start;
      logic result_load;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last_job;
      logic window_empty;
      logic elapsed_zero;
      logic div_busy;
      logic out_free;
   } dp_status_type;

   // buffer size saturated into 1..HISTORY_DEPTH, as a look-back distance
   function automatic logic [COUNT_WIDTH-1:0] clamp_buffer(input logic [BUFFER_WIDTH-1:0] size);
      logic [COUNT_WIDTH-1:0] wide;
      wide = COUNT_WIDTH'(size);
      if (wide == '0) begin
         return COUNT_WIDTH'(1);
      end else if (wide > COUNT_WIDTH'(HISTORY_DEPTH)) begin
         return COUNT_WIDTH'(HISTORY_DEPTH);
      end
      return wide;
   endfunction

endpackage

FILE: rtl/core/tandem_line_departure_sim.sv
// ----------------------------------------------------------------------------
// tandem_line_departure_sim
// Three-stage flow line with blocking after service, max-plus departure
// recurrence, and throughput over the measurement window at end of run.
// ----------------------------------------------------------------------------
// Each accepted job passes through these states: accept and read both departure
// histories, then four dependent add-or-max steps (stage one departure, stage
// two finish, stage two departure, stage three departure), then write the
// histories back. The job that ends a run adds an evaluation state, a wait on
// the bit-serial divider when the window is valid, and a load of the result
// register, which also waits if the previous result has not been taken. A
// result waiting at the output does not stop the next job from being accepted.
// Histories need no clearing after reset or between runs: a look-back before
// job one is recognized from the job number and reads as zero.
module tandem_line_departure_sim (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // first_service_time, second_service_time, third_service_time
   input  logic [tldsim_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // throughput, elapsed_time
   output logic [tldsim_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // invalid_window
   output logic [tldsim_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser,
   input  logic                                      csr_we,
   input  logic [tldsim_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tldsim_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   tldsim_pkg::dp_cmd_type    cmd;
   tldsim_pkg::dp_status_type status;

   tldsim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tldsim_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // one job at a time: no second transaction right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a job is in progress");

   // a result is only produced by a job in progress
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared with no job in progress");

   // a valid throughput comes with a nonzero elapsed time
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (rsp_tdata[tldsim_pkg::RSP_DATA_WIDTH-1:tldsim_pkg::THROUGHPUT_WIDTH] != '0))
      else $error("valid window reported with zero elapsed time");

endmodule

FILE: rtl/core/tldsim_div.sv
// ----------------------------------------------------------------------------
// tldsim_div
// Restoring divider, one quotient bit per cycle, for the end-of-run
// throughput figure.
// ----------------------------------------------------------------------------
module tldsim_div (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [tldsim_pkg::DIVIDEND_WIDTH-1:0]      dividend,
   input  logic [tldsim_pkg::TIME_WIDTH-1:0]          divisor,
   output logic                                       busy,
   output logic [tldsim_pkg::DIVIDEND_WIDTH-1:0]      quotient
);

   logic                                       busy_ff, busy_in;
   logic [tldsim_pkg::DIV_COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [tldsim_pkg::TIME_WIDTH-1:0]          rem_ff, rem_in;
   logic [tldsim_pkg::DIVIDEND_WIDTH-1:0]      quo_ff, quo_in;
   logic [tldsim_pkg::TIME_WIDTH-1:0]          divisor_ff, divisor_in;
   logic [tldsim_pkg::TIME_WIDTH:0]            rem_shift;
   logic [tldsim_pkg::TIME_WIDTH:0]            rem_sub;
   logic                                       take;

   // shift in the next dividend bit and try the subtract
   assign rem_shift = {rem_ff, quo_ff[tldsim_pkg::DIVIDEND_WIDTH-1]};
   assign take      = rem_shift >= {1'b0, divisor_ff};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = tldsim_pkg::DIV_COUNT_WIDTH'(tldsim_pkg::DIVIDEND_WIDTH - 1);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = take ? rem_sub[tldsim_pkg::TIME_WIDTH-1:0]
                         : rem_shift[tldsim_pkg::TIME_WIDTH-1:0];
         quo_in   = {quo_ff[tldsim_pkg::DIVIDEND_WIDTH-2:0], take};
         count_in = count_ff - tldsim_pkg::DIV_COUNT_WIDTH'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/tldsim_datapath.sv
// ----------------------------------------------------------------------------
// tldsim_datapath
// Configuration registers, departure histories, the per-stage add-and-max
// steps, the throughput divider and the result register.
// ----------------------------------------------------------------------------
module tldsim_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tldsim_pkg::dp_cmd_type                    cmd,
   output tldsim_pkg::dp_status_type                 status,
   // first_service_time, second_service_time, third_service_time
   input  logic [tldsim_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   input  logic                                      csr_we,
   input  logic [tldsim_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tldsim_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // throughput, elapsed_time
   output logic [tldsim_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // invalid_window
   output logic [tldsim_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser
);

   localparam int TW = tldsim_pkg::TIME_WIDTH;
   localparam int SW = tldsim_pkg::SERVICE_WIDTH;
   localparam int CW = tldsim_pkg::COUNT_WIDTH;
   localparam int BW = tldsim_pkg::BUFFER_WIDTH;
   localparam int AW = tldsim_pkg::HIST_ADDR_WIDTH;
   localparam int QW = tldsim_pkg::THROUGHPUT_WIDTH;
   localparam int DW = tldsim_pkg::DIVIDEND_WIDTH;

   // configuration
   logic [CW-1:0] job_count_ff, job_count_in;
   logic [CW-1:0] burnin_count_ff, burnin_count_in;
   logic [BW-1:0] first_buffer_ff, first_buffer_in;
   logic [BW-1:0] second_buffer_ff, second_buffer_in;

   // run and job state
   logic [CW-1:0] job_index_ff, job_index_in;
   logic [CW-1:0] job_ff, job_in;
   logic [SW-1:0] s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic          valid2_ff, valid2_in, valid3_ff, valid3_in;
   logic [TW-1:0] last1_ff, last1_in;
   logic [TW-1:0] prev2_ff, prev2_in;
   logic [TW-1:0] prev3_ff, prev3_in;
   logic [TW-1:0] burnin_dep_ff, burnin_dep_in;
   logic [TW-1:0] m2_ff, m2_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [TW-1:0] elapsed_ff, elapsed_in;

   // result register
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [QW-1:0] out_tp_ff, out_tp_in;
   logic [TW-1:0] out_el_ff, out_el_in;
   logic          out_inv_ff, out_inv_in;

   // histories
   logic [TW-1:0] hist2_mem [tldsim_pkg::HISTORY_DEPTH];
   logic [TW-1:0] hist3_mem [tldsim_pkg::HISTORY_DEPTH];
   logic [TW-1:0] rd2_ff, rd3_ff;

   logic [CW-1:0] count_eff;
   logic [CW-1:0] back1, back2;
   logic [CW-1:0] job_next;
   logic [CW-1:0] look1, look2;
   logic          run_start;
   logic [TW-1:0] lb2, lb3;
   logic [TW-1:0] sum1, max2, max3;
   logic          last_job, window_empty, elapsed_zero;
   logic [CW-1:0] window_jobs;
   logic [DW-1:0] dividend;
   logic [DW-1:0] quotient;
   logic          div_busy;

   // effective counts and look-back positions for the next job
   assign count_eff = (job_count_ff == '0) ? CW'(1) : job_count_ff;
   assign back1     = tldsim_pkg::clamp_buffer(first_buffer_ff);
   assign back2     = tldsim_pkg::clamp_buffer(second_buffer_ff);
   assign job_next  = job_index_ff + CW'(1);
   assign run_start = job_index_ff == '0;
   assign look1     = job_next - back1;
   assign look2     = job_next - back2;

   // departures before job one read as zero
   assign lb2 = valid2_ff ? rd2_ff : '0;
   assign lb3 = valid3_ff ? rd3_ff : '0;

   assign sum1 = last1_ff + TW'(s1_ff);
   assign max2 = (prev2_ff > last1_ff) ? prev2_ff : last1_ff;
   assign max3 = (prev3_ff > d2_ff) ? prev3_ff : d2_ff;

   assign last_job     = job_ff >= count_eff;
   assign window_empty = burnin_count_ff >= count_eff;
   assign elapsed_zero = elapsed_ff == '0;

   // history memories: read at accept, written when the job wraps up
   always_ff @(posedge clock) begin
      if (cmd.wrap) begin
         hist2_mem[job_ff[AW-1:0]] <= d2_ff;
         hist3_mem[job_ff[AW-1:0]] <= d3_ff;
      end
      if (cmd.load) begin
         rd2_ff <= hist2_mem[look1[AW-1:0]];
         rd3_ff <= hist3_mem[look2[AW-1:0]];
      end
   end

   // next-state logic
   always_comb begin
      job_count_in     = job_count_ff;
      burnin_count_in  = burnin_count_ff;
      first_buffer_in  = first_buffer_ff;
      second_buffer_in = second_buffer_ff;
      job_index_in     = job_index_ff;
      job_in           = job_ff;
      s1_in            = s1_ff;
      s2_in            = s2_ff;
      s3_in            = s3_ff;
      valid2_in        = valid2_ff;
      valid3_in        = valid3_ff;
      last1_in         = last1_ff;
      prev2_in         = prev2_ff;
      prev3_in         = prev3_ff;
      burnin_dep_in    = burnin_dep_ff;
      m2_in            = m2_ff;
      d2_in            = d2_ff;
      d3_in            = d3_ff;
      elapsed_in       = elapsed_ff;
      out_tp_in        = out_tp_ff;
      out_el_in        = out_el_ff;
      out_inv_in       = out_inv_ff;
      rsp_tvalid_in    = rsp_tready ? 1'b0 : rsp_tvalid_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            tldsim_pkg::CSR_JOB_COUNT:     job_count_in     = csr_wdata[CW-1:0];
            tldsim_pkg::CSR_BURNIN_COUNT:  burnin_count_in  = csr_wdata[CW-1:0];
            tldsim_pkg::CSR_FIRST_BUFFER:  first_buffer_in  = csr_wdata[BW-1:0];
            tldsim_pkg::CSR_SECOND_BUFFER: second_buffer_in = csr_wdata[BW-1:0];
            default: ;
         endcase
      end

      // accept a job; a new run starts from cleared departures
      if (cmd.load) begin
         s1_in     = req_tdata[SW-1:0];
         s2_in     = req_tdata[2*SW-1:SW];
         s3_in     = req_tdata[3*SW-1:2*SW];
         job_in    = job_next;
         valid2_in = job_next > back1;
         valid3_in = job_next > back2;
         if (run_start) begin
            last1_in      = '0;
            prev2_in      = '0;
            prev3_in      = '0;
            burnin_dep_in = '0;
         end
      end

      // stage one departure
      if (cmd.step1) begin
         last1_in = (sum1 > lb2) ? sum1 : lb2;
      end

      // stage two finish
      if (cmd.step2) begin
         m2_in = max2 + TW'(s2_ff);
      end

      // stage two departure, blocked by stage three
      if (cmd.step3) begin
         d2_in = (m2_ff > lb3) ? m2_ff : lb3;
      end

      // stage three departure
      if (cmd.step4) begin
         d3_in = max3 + TW'(s3_ff);
      end

      // close the job
      if (cmd.wrap) begin
         prev2_in     = d2_ff;
         prev3_in     = d3_ff;
         job_index_in = last_job ? '0 : job_ff;
         elapsed_in   = d3_ff - burnin_dep_ff;
         if (job_ff == burnin_count_ff) begin
            burnin_dep_in = d3_ff;
         end
      end

      // end-of-run result
      if (cmd.result_load) begin
         rsp_tvalid_in = 1'b1;
         if (window_empty) begin
            out_tp_in  = '1;
            out_el_in  = '0;
            out_inv_in = 1'b1;
         end else if (elapsed_zero) begin
            out_tp_in  = '1;
            out_el_in  = elapsed_ff;
            out_inv_in = 1'b1;
         end else begin
            out_tp_in  = (quotient[DW-1:QW] != '0) ? '1 : quotient[QW-1:0];
            out_el_in  = elapsed_ff;
            out_inv_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff     <= tldsim_pkg::JOB_COUNT_RESET;
         burnin_count_ff  <= tldsim_pkg::BURNIN_COUNT_RESET;
         first_buffer_ff  <= tldsim_pkg::BUFFER_SIZE_RESET;
         second_buffer_ff <= tldsim_pkg::BUFFER_SIZE_RESET;
         job_index_ff     <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         job_count_ff     <= job_count_in;
         burnin_count_ff  <= burnin_count_in;
         first_buffer_ff  <= first_buffer_in;
         second_buffer_ff <= second_buffer_in;
         job_index_ff     <= job_index_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      s3_ff         <= s3_in;
      valid2_ff     <= valid2_in;
      valid3_ff     <= valid3_in;
      last1_ff      <= last1_in;
      prev2_ff      <= prev2_in;
      prev3_ff      <= prev3_in;
      burnin_dep_ff <= burnin_dep_in;
      m2_ff         <= m2_in;
      d2_ff         <= d2_in;
      d3_ff         <= d3_in;
      elapsed_ff    <= elapsed_in;
      out_tp_ff     <= out_tp_in;
      out_el_ff     <= out_el_in;
      out_inv_ff    <= out_inv_in;
   end

   // throughput = window jobs, scaled to UQ16.16, over elapsed time
   assign window_jobs = count_eff - burnin_count_ff;
   assign dividend    = {window_jobs,
                         {(tldsim_pkg::TIME_FRACTION_BITS
                           + tldsim_pkg::THROUGHPUT_FRACTION_BITS){1'b0}}};

   tldsim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (elapsed_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // status back to the controller
   assign status.last_job     = last_job;
   assign status.window_empty = window_empty;
   assign status.elapsed_zero = elapsed_zero;
   assign status.div_busy     = div_busy;
   assign status.out_free     = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {out_el_ff, out_tp_ff};
   assign rsp_tuser  = out_inv_ff;

endmodule

FILE: rtl/core/tldsim_ctrl.sv
// ----------------------------------------------------------------------------
// tldsim_ctrl
// Sequencer for one job through the three stages and for the end-of-run
// throughput evaluation.
// ----------------------------------------------------------------------------
module tldsim_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  tldsim_pkg::dp_status_type   status,
   output tldsim_pkg::dp_cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_STEP1  = 4'd1;
   localparam logic [3:0] ST_STEP2  = 4'd2;
   localparam logic [3:0] ST_STEP3  = 4'd3;
   localparam logic [3:0] ST_STEP4  = 4'd4;
   localparam logic [3:0] ST_WRAP   = 4'd5;
   localparam logic [3:0] ST_EVAL   = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_RESULT = 4'd8;

   logic [3:0] state_ff, state_in;

   // transitions and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP1;
            end
         end
         ST_STEP1: begin
            cmd.step1 = 1'b1;
            state_in  = ST_STEP2;
         end
         ST_STEP2: begin
            cmd.step2 = 1'b1;
            state_in  = ST_STEP3;
         end
         ST_STEP3: begin
            cmd.step3 = 1'b1;
            state_in  = ST_STEP4;
         end
         ST_STEP4: begin
            cmd.step4 = 1'b1;
            state_in  = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = status.last_job ? ST_EVAL : ST_IDLE;
         end
         ST_EVAL: begin
            if (status.window_empty || status.elapsed_zero) begin
               state_in = ST_RESULT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule
